// ===== design/polled_slave_packet_queue_macros.svh =====
// Assertion macros for the polled slave packet queue checker.
// Expect i_clk and i_rst_n to be visible where they are used.
`ifndef POLLED_SLAVE_PACKET_QUEUE_MACROS_SVH
`define POLLED_SLAVE_PACKET_QUEUE_MACROS_SVH

// same-cycle implication, off while in reset
`define PSQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("psq assertion failed");

// next-cycle implication, off while in reset
`define PSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("psq assertion failed");

// next-cycle implication that also covers reset itself
`define PSQ_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("psq reset assertion failed");

`endif

// ===== design/psq_pkg.sv =====
// Shared types and constants of the polled slave packet queue.
// No dependencies.
package psq_pkg;

    localparam logic       OP_BUS   = 1'b0;
    localparam logic       OP_ENQ   = 1'b1;
    localparam logic       KIND_BUS = 1'b0;
    localparam logic       KIND_FWD = 1'b1;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_CR   = 8'h0D;

    localparam int ADDR_W = 3;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ADDR,
        PH_FRAME
    } t_phase;

    typedef enum logic [1:0] {
        CMD_ENQ,
        CMD_FWD,
        CMD_POLL
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LEN,
        B_SEND,
        B_CR
    } t_back_state;

endpackage

// ===== design/polled_slave_packet_queue.sv =====
// Top level of the polled slave packet queue: front end, command queue, back end.
// Depends on psq_pkg, psq_front, psq_cmd_fifo, psq_back.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | start, busy (out), i_opcode, i_data_byte  | in
//  result   | o_strobe, o_result_kind, o_out_byte, o_last | out
//  config   | i_cfg_we, i_cfg_wdata                     | in
//
// The back end handles an enqueue, a forwarded frame byte or an empty poll answer in
// B_IDLE, and a poll answer in B_LEN, then B_SEND and B_CR at one result beat per
// cycle, each byte read from the packet RAM and a CR beat added after each LF.
// busy rises when the two-entry command queue is full. Synchronous reset clears all
// control state; the packet RAM is not cleared. Results are registered.
module polled_slave_packet_queue
    import psq_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_opcode,
    input  logic [7:0]        i_data_byte,
    output logic              o_strobe,
    output logic              o_result_kind,
    output logic [7:0]        o_out_byte,
    output logic              o_last,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata
);

    logic [ADDR_W-1:0] r_dev_addr;
    logic              accept;
    logic              push, pop, q_valid, q_full;
    t_cmd              front_cmd, q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= ADDR_W'(1);
        end else if (i_cfg_we) begin
            r_dev_addr <= i_cfg_wdata;
        end
    end

    assign busy   = q_full;
    assign accept = start && !busy;

    psq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .i_dev_addr  (r_dev_addr),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    psq_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    psq_back #(
        .DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_pop         (pop),
        .o_strobe      (o_strobe),
        .o_result_kind (o_result_kind),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last)
    );

endmodule

// ===== design/psq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/psq_front.sv =====
// Front end: tracks bus framing and turns accepted beats into commands.
// Depends on psq_pkg.
module psq_front
    import psq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_opcode,
    input  logic [7:0]        i_data_byte,
    input  logic [ADDR_W-1:0] i_dev_addr,
    output logic              o_push,
    output t_cmd              o_cmd
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_fbl, n_fbl;
    logic [7:0] fbl_dec;

    assign fbl_dec = (r_fbl != 8'd0) ? r_fbl - 8'd1 : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_fbl   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_fbl   <= n_fbl;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_fbl      = r_fbl;
        o_push     = 1'b0;
        o_cmd.op   = CMD_FWD;
        o_cmd.data = i_data_byte;
        if (i_accept) begin
            if (i_opcode == OP_ENQ) begin
                o_push   = 1'b1;
                o_cmd.op = CMD_ENQ;
            end else begin
                unique case (r_phase)
                    PH_ADDR: begin
                        n_phase = PH_IDLE;
                        if (i_data_byte == {{(8-ADDR_W){1'b0}}, i_dev_addr}) begin
                            o_push   = 1'b1;
                            o_cmd.op = CMD_POLL;
                        end
                    end
                    PH_FRAME: begin
                        o_push = 1'b1;
                        n_fbl  = fbl_dec;
                        if (fbl_dec == 8'd0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_IDLE: begin
                        if (i_data_byte == BYTE_ZERO) begin
                            n_phase = PH_ADDR;
                        end else begin
                            o_push  = 1'b1;
                            n_fbl   = i_data_byte;
                            n_phase = PH_FRAME;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

endmodule

// ===== design/psq_cmd_fifo.sv =====
// Short command queue between front end and back end.
// Depends on psq_pkg.
module psq_cmd_fifo
    import psq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_cmd
);

    t_cmd                 r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   r_wp, r_rp;
    logic [CMDQ_CW-1:0]   r_cnt;
    logic                 do_push, do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CMDQ_CW'(CMDQ_DEPTH));
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== design/psq_back.sv =====
// Back end: packet store in a circular RAM, enqueue, poll answers, forwarding.
// Depends on psq_pkg and psq_ram.
module psq_back
    import psq_pkg::*;
#(
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH),
    localparam int FW   = $clog2(DEPTH + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_strobe,
    output logic       o_result_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    localparam logic [AW:0]   DEPTH_W  = (AW+1)'(DEPTH);
    localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

    t_back_state   r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic [8:0]    r_ebl, n_ebl;
    logic          r_ready, n_ready;
    logic [FW-1:0] r_left, n_left;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic          r_strobe, n_strobe;
    logic          r_kind, n_kind;
    logic [7:0]    r_byte, n_byte;
    logic          r_last, n_last;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;

    logic [8:0]    ebl_eff;
    logic [8:0]    len9;
    logic [FW-1:0] len_sel;
    logic [AW:0]   wsum, hsum;

    function automatic logic [AW-1:0] f_wrap(input logic [AW:0] s);
        return (s >= DEPTH_W) ? AW'(s - DEPTH_W) : s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    psq_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ebl_eff   = (r_ebl == 9'd0) ? {1'b0, i_cmd.data} + 9'd1 : r_ebl;
    assign wsum      = {1'b0, r_head} + (AW+1)'(r_fill);
    assign ram_waddr = f_wrap(wsum);
    assign len9      = {1'b0, ram_rdata} + 9'd1;
    assign len_sel   = (len9 > 9'(r_fill)) ? r_fill : len9[FW-1:0];
    assign hsum      = {1'b0, r_head} + (AW+1)'(len_sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_head   <= '0;
            r_fill   <= '0;
            r_ebl    <= '0;
            r_ready  <= 1'b0;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_ebl    <= n_ebl;
            r_ready  <= n_ready;
            r_left   <= n_left;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_kind   <= n_kind;
        r_byte   <= n_byte;
        r_last   <= n_last;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_fill    = r_fill;
        n_ebl     = r_ebl;
        n_ready   = r_ready;
        n_left    = r_left;
        n_rd_ptr  = r_rd_ptr;
        n_strobe  = 1'b0;
        n_kind    = KIND_BUS;
        n_byte    = r_byte;
        n_last    = 1'b0;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_rd_ptr;
        unique case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        CMD_ENQ: begin
                            if (r_fill < FILL_MAX) begin
                                ram_we = 1'b1;
                                n_fill = r_fill + 1'b1;
                                n_ebl  = ebl_eff - 9'd1;
                                if (ebl_eff == 9'd1) begin
                                    n_ready = 1'b1;
                                end
                            end else begin
                                n_ebl = ebl_eff;
                            end
                        end
                        CMD_FWD: begin
                            n_strobe = 1'b1;
                            n_kind   = KIND_FWD;
                            n_byte   = i_cmd.data;
                            n_last   = 1'b1;
                        end
                        CMD_POLL: begin
                            if (r_ready && (r_fill != '0)) begin
                                ram_re    = 1'b1;
                                ram_raddr = r_head;
                                n_rd_ptr  = f_inc(r_head);
                                n_state   = B_LEN;
                            end else begin
                                n_strobe = 1'b1;
                                n_byte   = BYTE_ZERO;
                                n_last   = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            B_LEN: begin
                // head byte is on the RAM output; it also stays there for B_SEND
                n_left  = len_sel;
                n_head  = f_wrap(hsum);
                n_fill  = r_fill - len_sel;
                if (r_fill == len_sel) begin
                    n_ready = 1'b0;
                end
                n_state = B_SEND;
            end
            B_SEND: begin
                n_strobe = 1'b1;
                n_byte   = ram_rdata;
                n_left   = r_left - 1'b1;
                if (r_left != FW'(1)) begin
                    ram_re   = 1'b1;
                    n_rd_ptr = f_inc(r_rd_ptr);
                end
                if (ram_rdata == BYTE_LF) begin
                    n_state = B_CR;
                end else if (r_left == FW'(1)) begin
                    n_last  = 1'b1;
                    n_state = B_IDLE;
                end
            end
            B_CR: begin
                n_strobe = 1'b1;
                n_byte   = BYTE_CR;
                if (r_left == '0) begin
                    n_last  = 1'b1;
                    n_state = B_IDLE;
                end else begin
                    n_state = B_SEND;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_strobe      = r_strobe;
    assign o_result_kind = r_kind;
    assign o_out_byte    = r_byte;
    assign o_last        = r_last;

endmodule

// ===== design/psq_checker.sv =====
// Port-level checks for the polled slave packet queue, bound to the top level.
// Depends on psq_pkg and polled_slave_packet_queue_macros.svh.
`include "polled_slave_packet_queue_macros.svh"

module psq_checker
    import psq_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       busy,
    input logic       o_strobe,
    input logic       o_result_kind,
    input logic [7:0] o_out_byte,
    input logic       o_last
);

    logic sent_lf;
    logic sent_cr;

    assign sent_lf = o_strobe && (o_result_kind == KIND_BUS) && (o_out_byte == BYTE_LF);
    assign sent_cr = o_strobe && (o_result_kind == KIND_BUS) && (o_out_byte == BYTE_CR);

    `PSQ_ASSERT_RST(a_rst_quiet, !i_rst_n, !o_strobe && !busy)
    `PSQ_ASSERT_NEXT(a_lf_then_cr, sent_lf, sent_cr)
    `PSQ_ASSERT_NOW(a_lf_not_last, sent_lf, !o_last)
    `PSQ_ASSERT_NOW(a_fwd_single, o_strobe && (o_result_kind == KIND_FWD), o_last)

endmodule

bind polled_slave_packet_queue psq_checker u_psq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_result_kind (o_result_kind),
    .o_out_byte    (o_out_byte),
    .o_last        (o_last)
);

// ===== test/polled_slave_packet_queue_tb.sv =====
// Self-checking testbench for polled_slave_packet_queue: random and directed bus and enqueue
// beats, with predicted poll answers and forwarded frame bytes checked in order.
// Depends on psq_pkg and the polled_slave_packet_queue RTL.
module polled_slave_packet_queue_tb;
    import psq_pkg::*;

    localparam int BUFFER_DEPTH = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic       op;
        logic [7:0] value;
    } t_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } t_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_opcode = OP_BUS;
    logic [7:0]        i_data_byte = 8'h00;
    logic              o_strobe;
    logic              o_result_kind;
    logic [7:0]        o_out_byte;
    logic              o_last;
    logic              i_cfg_we = 1'b0;
    logic [ADDR_W-1:0] i_cfg_wdata = '0;

    t_item   pending_beats[$];
    t_result awaited_results[$];
    t_item   next_beat;
    t_result want;
    int      beats_queued = 0;
    int      beats_taken = 0;
    int      burst_left = 0;
    int      gap_left = 0;
    int      error_count = 0;
    int      cycle_count = 0;

    // predicted slave state
    t_phase            bus_ph;
    logic [7:0]        frame_left;
    logic [7:0]        pkt_store [BUFFER_DEPTH];
    int unsigned       fill_level;
    logic [8:0]        enq_left;
    logic              pkt_ready;
    logic [ADDR_W-1:0] dev_addr;

    polled_slave_packet_queue #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_opcode(i_opcode),
        .i_data_byte(i_data_byte),
        .o_strobe(o_strobe),
        .o_result_kind(o_result_kind),
        .o_out_byte(o_out_byte),
        .o_last(o_last),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic void put_bus(ref t_result q[$], input logic [7:0] b);
        q.push_back('{KIND_BUS, b, 1'b0});
        if (b == BYTE_LF) begin
            q.push_back('{KIND_BUS, BYTE_CR, 1'b0});
        end
    endfunction

    function automatic void predict_results(logic op, logic [7:0] b);
        t_result     res[$];
        int unsigned len;
        if (op == OP_ENQ) begin
            if (enq_left == 0) enq_left = b + 9'd1;
            if (fill_level < BUFFER_DEPTH) begin
                pkt_store[fill_level] = b;
                fill_level++;
                enq_left--;
                if (enq_left == 0) pkt_ready = 1'b1;
            end
            return;
        end
        case (bus_ph)
            PH_ADDR: begin
                bus_ph = PH_IDLE;
                if (b == {{(8-ADDR_W){1'b0}}, dev_addr}) begin
                    if (!pkt_ready || fill_level == 0) begin
                        put_bus(res, BYTE_ZERO);
                    end else begin
                        len = pkt_store[0] + 1;
                        if (len > fill_level) len = fill_level;
                        for (int i = 0; i < len; i++) put_bus(res, pkt_store[i]);
                        for (int i = len; i < fill_level; i++) pkt_store[i-len] = pkt_store[i];
                        fill_level -= len;
                        if (fill_level == 0) pkt_ready = 1'b0;
                    end
                end
            end
            PH_FRAME: begin
                res.push_back('{KIND_FWD, b, 1'b0});
                if (frame_left > 0) frame_left--;
                if (frame_left == 0) bus_ph = PH_IDLE;
            end
            default: begin
                if (b == BYTE_ZERO) begin
                    bus_ph = PH_ADDR;
                end else begin
                    res.push_back('{KIND_FWD, b, 1'b0});
                    frame_left = b;
                    bus_ph = PH_FRAME;
                end
            end
        endcase
        if (res.size() > 0) res[$].last = 1'b1;
        foreach (res[i]) awaited_results.push_back(res[i]);
    endfunction

    // driver: bursts of beats from the pending queue, random gaps between bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) begin
                predict_results(i_opcode, i_data_byte);
                beats_taken++;
            end
            if (gap_left > 0 || pending_beats.size() == 0) begin
                start <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                next_beat = pending_beats.pop_front();
                i_opcode <= next_beat.op;
                i_data_byte <= next_beat.value;
                start <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result beat: result_kind %0d out_byte %h last %0d",
                       o_result_kind, o_out_byte, o_last);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_result_kind !== want.kind) begin
                    $error("result_kind expected %0d actual %0d", want.kind, o_result_kind);
                    error_count++;
                end
                if (o_out_byte !== want.value) begin
                    $error("out_byte expected %h actual %h", want.value, o_out_byte);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $error("last expected %0d actual %0d", want.last, o_last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_item(logic op, logic [7:0] b);
        pending_beats.push_back('{op, b});
        beats_queued++;
    endtask

    task automatic push_poll();
        push_item(OP_BUS, BYTE_ZERO);
        push_item(OP_BUS, {{(8-ADDR_W){1'b0}}, dev_addr});
    endtask

    task automatic wait_drained();
        while (!(beats_taken == beats_queued && awaited_results.size() == 0)) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_address(logic [ADDR_W-1:0] a);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wdata <= a;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dev_addr = a;
    endtask

    // bring the bus back to idle so that new sequences line up
    task automatic resync_bus();
        wait_drained();
        if (bus_ph == PH_FRAME) begin
            repeat (frame_left) push_item(OP_BUS, 8'($urandom_range(0, 255)));
        end else if (bus_ph == PH_ADDR) begin
            push_item(OP_BUS, 8'($urandom_range(8, 255)));
        end
    endtask

    task automatic drain_store();
        resync_bus();
        wait_drained();
        while (fill_level > 0 && pkt_ready) begin
            push_poll();
            wait_drained();
        end
    endtask

    // mix of packets, polls and frames; packet and bus streams interleaved at random
    task automatic random_segment(int n_items);
        t_item       enq_q[$];
        t_item       bus_q[$];
        int unsigned est_fill;
        int          pick;
        int          len;
        logic [7:0]  other;
        resync_bus();
        wait_drained();
        est_fill = fill_level;
        while (enq_q.size() + bus_q.size() < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 31) : $urandom_range(0, 6);
                if (est_fill + len + 1 <= BUFFER_DEPTH) begin
                    enq_q.push_back('{OP_ENQ, 8'(len)});
                    repeat (len) enq_q.push_back('{OP_ENQ, 8'($urandom_range(0, 255))});
                    est_fill += len + 1;
                end else begin
                    bus_q.push_back('{OP_BUS, BYTE_ZERO});
                    bus_q.push_back('{OP_BUS, {{(8-ADDR_W){1'b0}}, dev_addr}});
                end
            end else if (pick < 65) begin
                bus_q.push_back('{OP_BUS, BYTE_ZERO});
                bus_q.push_back('{OP_BUS, {{(8-ADDR_W){1'b0}}, dev_addr}});
            end else if (pick < 85) begin
                len = $urandom_range(1, 6);
                bus_q.push_back('{OP_BUS, 8'(len)});
                repeat (len) bus_q.push_back('{OP_BUS, 8'($urandom_range(0, 255))});
            end else if (pick < 92) begin
                do begin
                    other = 8'($urandom_range(0, 255));
                end while (other == {{(8-ADDR_W){1'b0}}, dev_addr});
                bus_q.push_back('{OP_BUS, BYTE_ZERO});
                bus_q.push_back('{OP_BUS, other});
            end else if (pick < 97) begin
                len = $urandom_range(2, 8);
                bus_q.push_back('{OP_BUS, 8'(len)});
                repeat ($urandom_range(0, len - 1))
                    bus_q.push_back('{OP_BUS, 8'($urandom_range(0, 255))});
            end else begin
                bus_q.push_back('{OP_BUS,
                    8'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 255 : 15))});
            end
        end
        while (enq_q.size() > 0 || bus_q.size() > 0) begin
            if (bus_q.size() == 0 || (enq_q.size() > 0 && $urandom_range(0, 1) == 1)) begin
                next_beat = enq_q.pop_front();
            end else begin
                next_beat = bus_q.pop_front();
            end
            push_item(next_beat.op, next_beat.value);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] phase_addr [5];
        int                target;
        bus_ph = PH_IDLE;
        frame_left = 8'h00;
        fill_level = 0;
        enq_left = 9'd0;
        pkt_ready = 1'b0;
        dev_addr = ADDR_W'(1);
        foreach (pkt_store[i]) pkt_store[i] = 8'h00;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty poll, foreign and out-of-range addresses
        push_poll();
        push_item(OP_BUS, BYTE_ZERO);
        push_item(OP_BUS, 8'h05);
        push_item(OP_BUS, BYTE_ZERO);
        push_item(OP_BUS, 8'h80);
        // complete packet then a partial one; second poll clamps to fill
        push_item(OP_ENQ, 8'h01);
        push_item(OP_ENQ, 8'h55);
        push_item(OP_ENQ, 8'h05);
        push_item(OP_ENQ, BYTE_LF);
        push_item(OP_ENQ, 8'h80);
        push_poll();
        push_poll();
        // rest of the partial packet; its head length exceeds the fill
        push_item(OP_ENQ, 8'h12);
        push_item(OP_ENQ, 8'h34);
        push_item(OP_ENQ, BYTE_LF);
        push_poll();
        // forwarded frames
        push_item(OP_BUS, 8'h02);
        push_item(OP_BUS, BYTE_ZERO);
        push_item(OP_BUS, 8'hFF);
        push_item(OP_BUS, 8'h01);
        push_item(OP_BUS, BYTE_LF);

        phase_addr[0] = '0;
        phase_addr[1] = '1;
        phase_addr[2] = ADDR_W'(3);
        phase_addr[3] = ADDR_W'($urandom_range(0, 7));
        phase_addr[4] = ADDR_W'(6);
        foreach (phase_addr[p]) begin
            write_address(phase_addr[p]);
            target = beats_queued + 30;
            while (beats_queued < target) random_segment($urandom_range(10, 24));
        end

        // store overflow: full of complete packets, then dropped bytes
        write_address(ADDR_W'(1));
        drain_store();
        repeat (4) begin
            push_item(OP_ENQ, 8'h07);
            repeat (7) push_item(OP_ENQ, 8'($urandom_range(0, 255)));
        end
        push_item(OP_ENQ, 8'h03);
        push_item(OP_ENQ, 8'($urandom_range(0, 255)));
        push_item(OP_ENQ, 8'($urandom_range(0, 255)));
        push_poll();
        repeat (4) push_item(OP_ENQ, 8'($urandom_range(0, 255)));
        drain_store();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
